// ===== rtl/core/itra_pkg.sv =====
// ----------------------------------------------------------------------------
// itra_pkg
// Shared constants, types and the digit-to-character map for the
// integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int BITS_PER_CYCLE  = 4;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] remainder;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DEC_DIGITS) begin
      digit_char = CHAR_ZERO + CHAR_W'(d);
    end else begin
      digit_char = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    end
  endfunction

endpackage

// ===== rtl/core/itra_div.sv =====
// ----------------------------------------------------------------------------
// itra_div
// Iterative divider of a wide unsigned value by a small base (2..16),
// restoring, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module itra_div #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [itra_pkg::RADIX_W-1:0]  divisor,
  output logic [VALUE_WIDTH-1:0]        quotient,
  output itra_pkg::div_res_t            res
);
  import itra_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int PW    = STEPS * BITS_PER_CYCLE;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic [PW-1:0]      q;
  logic [PW-1:0]      q_next;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [CNTW-1:0]    cnt;
  logic               running;
  logic               done;

  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DIGIT_W:0]   t;
    r      = rem;
    q_next = q;
    for (int j = 0; j < BITS_PER_CYCLE; j++) begin
      t      = {r, q_next[PW-1]};
      q_next = {q_next[PW-2:0], 1'b0};
      if (t >= divisor) begin
        r         = DIGIT_W'(t - divisor);
        q_next[0] = 1'b1;
      end else begin
        r = DIGIT_W'(t);
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        q       <= PW'(dividend);
        rem     <= '0;
        cnt     <= CNTW'(STEPS);
        running <= 1'b1;
      end else if (running) begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient      = q[VALUE_WIDTH-1:0];
  assign res.done      = done;
  assign res.remainder = rem;

endmodule

// ===== rtl/core/integer_to_radix_ascii_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top
// Converts a signed integer into its ASCII text in a base from 2 to 16.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with value while busy is low; the transaction is taken at
//   that edge. Characters leave one per strobe cycle, most significant
//   first: '-' for negatives, then lower-case digits; last marks the end.
//   A zero value gives a single '0'. A radix outside 2..16 gives a single
//   strobe with character 0, last and bad_base set. The user must write
//   radix through cfg_we/cfg_wdata only while idle; it is not enforced.
// Timing:
//   Invalid base and zero: one strobe the cycle after start, no busy time.
//   Otherwise each digit costs one pass of the shared divider. Then each
//   character goes through the registered digit store read, in ST_RD and
//   then ST_EMIT; the minus sign is emitted from ST_SIGN before them.
// Reset:
//   rst clears the sequencer, the strobe and sets radix to 10.
//   Results cannot be held off: the receiver takes every strobe.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top #(
  parameter int VALUE_WIDTH = itra_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          cfg_we,
  input  logic [itra_pkg::RADIX_W-1:0]  cfg_wdata,
  output logic                          strobe,
  output logic [itra_pkg::CHAR_W-1:0]   character,
  output logic                          last,
  output logic                          bad_base
);
  import itra_pkg::*;

  localparam int CW   = $clog2(VALUE_WIDTH + 1);
  localparam int IDXW = $clog2(VALUE_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic [RADIX_W-1:0]     radix;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] uvalue;
  logic [VALUE_WIDTH-1:0] quotient;
  logic                   negative;
  logic [CW-1:0]          count;
  logic [IDXW-1:0]        idx;
  logic                   div_go;
  logic [DIGIT_W-1:0]     rd_data;
  logic [DIGIT_W-1:0]     digit_store [VALUE_WIDTH];
  div_res_t               div_res;
  logic                   accept;
  logic                   radix_ok;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign uvalue   = VALUE_WIDTH'(value);
  assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);

  itra_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (mag),
    .divisor  (radix),
    .quotient (quotient),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_res.done) begin
      digit_store[count[IDXW-1:0]] <= div_res.remainder;
    end
    rd_data <= digit_store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      strobe   <= 1'b0;
      div_go   <= 1'b0;
      negative <= 1'b0;
      count    <= '0;
      mag      <= '0;
      idx      <= '0;
    end else begin
      strobe <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!radix_ok) begin
              strobe    <= 1'b1;
              character <= CHAR_NONE;
              last      <= 1'b1;
              bad_base  <= 1'b1;
            end else if (uvalue == '0) begin
              negative  <= 1'b0;
              count     <= '0;
              mag       <= '0;
              strobe    <= 1'b1;
              character <= CHAR_ZERO;
              last      <= 1'b1;
              bad_base  <= 1'b0;
            end else begin
              negative <= uvalue[VALUE_WIDTH-1];
              mag      <= uvalue[VALUE_WIDTH-1] ? VALUE_WIDTH'(~uvalue + 1'b1) : uvalue;
              count    <= '0;
              div_go   <= 1'b1;
              state    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            mag   <= quotient;
            count <= count + 1'b1;
            idx   <= count[IDXW-1:0];
            if (quotient == '0 || count == CW'(VALUE_WIDTH - 1)) begin
              state <= negative ? ST_SIGN : ST_RD;
            end else begin
              div_go <= 1'b1;
            end
          end
        end
        ST_SIGN: begin
          strobe    <= 1'b1;
          character <= CHAR_MINUS;
          last      <= 1'b0;
          bad_base  <= 1'b0;
          state     <= ST_RD;
        end
        ST_RD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe    <= 1'b1;
          character <= digit_char(rd_data);
          last      <= (idx == '0);
          bad_base  <= 1'b0;
          if (idx == '0) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx - 1'b1;
            state <= ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an error result never overlaps an active conversion
  a_bad_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && bad_base |-> !busy)
    else $error("bad_base strobe during conversion");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside digit split");

  a_mag_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> mag != '0)
    else $error("zero magnitude under division");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && character == CHAR_MINUS |-> !last)
    else $error("minus sign marked as final character");

  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy) || $past(start))
    else $error("strobe without a transaction");

endmodule
